// ===== hdl/lz4bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lz4bsp_pkg
// Types and constants shared by the LZ4 block sequence parser modules.
// ----------------------------------------------------------------------------
package lz4bsp_pkg;

   // Field widths
   localparam int ByteW   = 8;
   localparam int PosW    = 22;
   localparam int LitLenW = 23;
   localparam int OffW    = 16;
   localparam int MatchW  = 24;

   // Saturation limits and token constants
   localparam logic [PosW-1:0]    PosMax      = '1;
   localparam logic [LitLenW-1:0] LitWidthMax = '1;
   localparam logic [MatchW-1:0]  MatchMax    = '1;
   localparam logic [3:0]         NibbleExt   = 4'hF;
   localparam logic [ByteW-1:0]   ByteExt     = 8'hFF;
   localparam logic [3:0]         MatchMinLen = 4'd4;
   localparam logic [MatchW-1:0]  MatchExtBase = 24'd19;

   // Queue between front and back
   localparam int QueueDepth = 4;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // Output stream packing
   localparam int RspDataW = 88;

   // Status codes
   localparam logic StatusOk        = 1'b0;
   localparam logic StatusTruncated = 1'b1;

   // Parse phases
   typedef enum logic [2:0] {
      PhToken,
      PhLitExt,
      PhLits,
      PhOffLo,
      PhOffHi,
      PhMExt
   } phase_type;

   // One classified byte as it travels from front to back
   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             block_last;
      logic             is_ext;
      logic [PosW-1:0]  position;
   } q_item_type;

   // One sequence command
   typedef struct packed {
      logic               status;
      logic               block_done;
      logic [MatchW-1:0]  match_length;
      logic [OffW-1:0]    match_offset;
      logic               has_match;
      logic [LitLenW-1:0] literal_length;
      logic [PosW-1:0]    literal_start;
   } cmd_type;

endpackage

// ===== hdl/lz4bsp_front.sv =====
// ----------------------------------------------------------------------------
// lz4bsp_front
// Accepts compressed bytes, tags each with its position in the block and
// whether it extends a length, and pushes it into the queue.
// ----------------------------------------------------------------------------
module lz4bsp_front
   import lz4bsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tlast,   // block_last
   input  logic             q_full,
   output logic             q_push,
   output q_item_type       q_item
);

   logic [PosW-1:0] pos_ff;
   logic [PosW-1:0] pos_in;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   // Classify the byte
   always_comb begin
      q_item.data_byte  = req_tdata;
      q_item.block_last = req_tlast;
      q_item.is_ext     = (req_tdata == ByteExt);
      q_item.position   = pos_ff;
   end

   // Advance the position, saturating; restart at each block end
   always_comb begin
      pos_in = pos_ff;
      if (q_push) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff != PosMax) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

// ===== hdl/lz4bsp_queue.sv =====
// ----------------------------------------------------------------------------
// lz4bsp_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module lz4bsp_queue
   import lz4bsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output q_item_type head_item
);

   q_item_type         entries_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff;
   logic [QPtrW-1:0]   rd_ptr_ff;
   logic [QCntW-1:0]   count_ff;
   logic [QCntW-1:0]   count_in;

   assign full       = (count_ff == QCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];

   // Track fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/lz4bsp_back.sv =====
// ----------------------------------------------------------------------------
// lz4bsp_back
// Parses queued bytes into sequences and holds each command in an output
// register until the consumer takes it.
// ----------------------------------------------------------------------------
module lz4bsp_back
   import lz4bsp_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = 4194304
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  q_item_type head_item,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    rsp_cmd
);

   localparam logic [LitLenW-1:0] LitCap =
      (MAX_BLOCK_BYTES > int'(LitWidthMax)) ? LitWidthMax : LitLenW'(MAX_BLOCK_BYTES);

   phase_type          phase_ff, phase_in;
   logic [3:0]         match_nib_ff, match_nib_in;
   logic [LitLenW-1:0] lit_accum_ff, lit_accum_in;
   logic [LitLenW-1:0] lit_rem_ff, lit_rem_in;
   logic [PosW-1:0]    lit_begin_ff, lit_begin_in;
   logic [ByteW-1:0]   off_lo_ff, off_lo_in;
   logic [OffW-1:0]    offset_ff, offset_in;
   logic [MatchW-1:0]  match_accum_ff, match_accum_in;
   logic               rsp_valid_ff;
   cmd_type            rsp_cmd_ff, cmd_in;
   logic               emit;

   logic [ByteW-1:0]   b;
   logic [3:0]         lit_nib;
   logic [PosW-1:0]    pos_next;
   logic [LitLenW:0]   lit_sum;
   logic [LitLenW-1:0] lit_sat;
   logic [MatchW:0]    match_sum;
   logic [MatchW-1:0]  match_sat;

   assign pop        = head_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_cmd    = rsp_cmd_ff;

   // Shared arithmetic on the head byte
   always_comb begin
      b         = head_item.data_byte;
      lit_nib   = b[7:4];
      pos_next  = (head_item.position == PosMax) ? PosMax : head_item.position + 1'b1;
      lit_sum   = {1'b0, lit_accum_ff} + (LitLenW+1)'(b);
      lit_sat   = (lit_sum > {1'b0, LitCap}) ? LitCap : lit_sum[LitLenW-1:0];
      match_sum = {1'b0, match_accum_ff} + (MatchW+1)'(b);
      match_sat = match_sum[MatchW] ? MatchMax : match_sum[MatchW-1:0];
   end

   // Next parse phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PhToken: begin
            if (lit_nib == NibbleExt) begin
               phase_in = PhLitExt;
            end else if (lit_nib != '0) begin
               phase_in = PhLits;
            end else begin
               phase_in = PhOffLo;
            end
         end
         PhLitExt: begin
            if (!head_item.is_ext) begin
               phase_in = (lit_sat != '0) ? PhLits : PhOffLo;
            end
         end
         PhLits: begin
            if (lit_rem_ff <= LitLenW'(1)) begin
               phase_in = PhOffLo;
            end
         end
         PhOffLo: phase_in = PhOffHi;
         PhOffHi: phase_in = (match_nib_ff == NibbleExt) ? PhMExt : PhToken;
         PhMExt: begin
            if (!head_item.is_ext) begin
               phase_in = PhToken;
            end
         end
         default: phase_in = PhToken;
      endcase
      if (head_item.block_last) begin
         phase_in = PhToken;
      end
   end

   // Field updates and command build
   always_comb begin
      match_nib_in   = match_nib_ff;
      lit_accum_in   = lit_accum_ff;
      lit_rem_in     = lit_rem_ff;
      lit_begin_in   = lit_begin_ff;
      off_lo_in      = off_lo_ff;
      offset_in      = offset_ff;
      match_accum_in = match_accum_ff;
      emit           = 1'b0;
      cmd_in         = '0;
      unique case (phase_ff)
         PhToken: begin
            match_nib_in = b[3:0];
            if (lit_nib == NibbleExt) begin
               lit_begin_in = '0;
               lit_accum_in = LitLenW'(15);
            end else begin
               lit_begin_in = pos_next;
               lit_accum_in = LitLenW'(lit_nib);
               lit_rem_in   = LitLenW'(lit_nib);
            end
         end
         PhLitExt: begin
            lit_accum_in = lit_sat;
            if (!head_item.is_ext) begin
               lit_begin_in = pos_next;
               lit_rem_in   = lit_sat;
            end
         end
         PhLits: begin
            if (lit_rem_ff != '0) begin
               lit_rem_in = lit_rem_ff - 1'b1;
            end
         end
         PhOffLo: off_lo_in = b;
         PhOffHi: begin
            offset_in = {b, off_lo_ff};
            if (match_nib_ff == NibbleExt) begin
               match_accum_in = MatchExtBase;
            end else begin
               emit                = 1'b1;
               cmd_in.has_match    = 1'b1;
               cmd_in.match_offset = {b, off_lo_ff};
               cmd_in.match_length = MatchW'(match_nib_ff) + MatchW'(MatchMinLen);
            end
         end
         PhMExt: begin
            match_accum_in = match_sat;
            if (!head_item.is_ext) begin
               emit                = 1'b1;
               cmd_in.has_match    = 1'b1;
               cmd_in.match_offset = offset_ff;
               cmd_in.match_length = match_sat;
            end
         end
         default: begin
            match_nib_in = match_nib_ff;
         end
      endcase
      cmd_in.literal_start  = lit_begin_in;
      cmd_in.literal_length = lit_accum_in;
      cmd_in.block_done     = head_item.block_last;
      cmd_in.status         = StatusOk;
      // Close the block: final literal-only command or truncation report
      if (head_item.block_last && !emit) begin
         emit = 1'b1;
         if (phase_ff == PhToken && lit_nib != NibbleExt && lit_nib == '0) begin
            cmd_in.status = StatusOk;
         end else if (phase_ff == PhLitExt && !head_item.is_ext && lit_sat == '0) begin
            cmd_in.status = StatusOk;
         end else if (phase_ff == PhLits && lit_rem_ff <= LitLenW'(1)) begin
            cmd_in.status = StatusOk;
         end else begin
            cmd_in.status = StatusTruncated;
         end
      end
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhToken;
      end else if (pop) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         match_nib_ff   <= match_nib_in;
         lit_accum_ff   <= lit_accum_in;
         lit_rem_ff     <= lit_rem_in;
         lit_begin_ff   <= lit_begin_in;
         off_lo_ff      <= off_lo_in;
         offset_ff      <= offset_in;
         match_accum_ff <= match_accum_in;
      end
   end

   // Output register: load on emit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== hdl/lz4_block_sequence_parser_top.sv =====
// ----------------------------------------------------------------------------
// lz4_block_sequence_parser_top
// Parses an LZ4 compressed block, one byte per transaction, into sequence
// commands. A byte passes through the queue to the back; the command it ends
// is held in the output register. Throughput: 1 byte per cycle, set by the
// single-byte parse step in the back, while the output register is empty or
// taken. A 4-entry queue decouples byte intake from command output stalls.
// Reset (synchronous, active high) empties the queue and output register
// and returns the parser to expecting a token at position zero.
// ----------------------------------------------------------------------------
module lz4_block_sequence_parser_top
   import lz4bsp_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = 4194304
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // block_last
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // literal_start, literal_length,
                                            // has_match, match_offset,
                                            // match_length, zero pad
   output logic                rsp_tlast,   // block_done
   output logic                rsp_tuser    // status
);

   logic       q_full;
   logic       q_push;
   q_item_type q_item;
   logic       q_pop;
   logic       q_head_valid;
   q_item_type q_head;
   cmd_type    cmd;

   lz4bsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_item)
   );

   lz4bsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head)
   );

   lz4bsp_back #(
      .MAX_BLOCK_BYTES (MAX_BLOCK_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_item  (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cmd    (cmd)
   );

   // Pack the command onto the stream
   assign rsp_tdata = {2'b00, cmd.match_length, cmd.match_offset, cmd.has_match,
                       cmd.literal_length, cmd.literal_start};
   assign rsp_tlast = cmd.block_done;
   assign rsp_tuser = cmd.status;

endmodule

// ===== bench/lz4bsp_sequence_checker.sv =====
// ----------------------------------------------------------------------------
// lz4bsp_sequence_checker
// Watches the byte and command channels of the LZ4 block sequence parser,
// predicts the sequence commands that the accepted bytes cause, and compares
// every accepted command field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module lz4bsp_sequence_checker
   import lz4bsp_pkg::*;
#(
   parameter int MAX_BLOCK_BYTES = 4194304
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                req_tlast,   // block_last
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,   // literal_start, literal_length,
                                            // has_match, match_offset,
                                            // match_length, zero pad
   input  logic                rsp_tlast,   // block_done
   input  logic                rsp_tuser,   // status
   output int                  mismatch_count,
   output int                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Bit offsets of the command fields in rsp_tdata
   localparam int LenLo   = PosW;
   localparam int MatchHm = PosW + LitLenW;
   localparam int OffLo   = MatchHm + 1;
   localparam int MlenLo  = OffLo + OffW;

   // Literal length saturates at the block size or the field width
   localparam int unsigned LitCap =
      (MAX_BLOCK_BYTES > 2**LitLenW - 1) ? 2**LitLenW - 1 : MAX_BLOCK_BYTES;

   // Predictor state
   phase_type          phase;
   logic [PosW-1:0]    position;
   logic [ByteW-1:0]   token;
   logic [LitLenW-1:0] lit_len;
   logic [LitLenW-1:0] lit_left;
   logic [PosW-1:0]    lit_start;
   logic [ByteW-1:0]   off_lo;
   logic [ByteW-1:0]   off_hi;
   logic [MatchW-1:0]  match_len;

   cmd_type pending_cmds[$];
   int      errors = 0;
   int      pending = 0;
   int      cmd_index = 0;

   assign mismatch_count = errors;
   assign pending_count  = pending;

   function automatic logic [PosW-1:0] next_pos(input logic [PosW-1:0] p);
      return (p == PosMax) ? p : p + 1'b1;
   endfunction

   task automatic clear_state();
      phase     = PhToken;
      position  = '0;
      token     = '0;
      lit_len   = '0;
      lit_left  = '0;
      lit_start = '0;
      off_lo    = '0;
      off_hi    = '0;
      match_len = '0;
   endtask

   // Record where the literals begin once their length is settled
   task automatic length_known();
      lit_start = next_pos(position);
      lit_left  = lit_len;
      phase     = (lit_len != 0) ? PhLits : PhOffLo;
   endtask

   function automatic cmd_type make_cmd(input logic hm, input logic [MatchW-1:0] ml,
                                        input logic done, input logic st);
      cmd_type c;
      c.literal_start  = lit_start;
      c.literal_length = lit_len;
      c.has_match      = hm;
      c.match_offset   = hm ? {off_hi, off_lo} : '0;
      c.match_length   = hm ? ml : '0;
      c.block_done     = done;
      c.status         = st;
      return c;
   endfunction

   // Advance the parse by one byte; emit is set when a command results
   task automatic parse_byte(input logic [7:0] b, input logic is_last,
                             output bit emit, output cmd_type cmd);
      int unsigned sum;
      emit = 1'b0;
      cmd  = '0;
      case (phase)
         PhLitExt: begin
            sum = 32'(lit_len) + 32'(b);
            lit_len = (sum > LitCap) ? LitLenW'(LitCap) : LitLenW'(sum);
            if (b != ByteExt) length_known();
         end
         PhLits: begin
            if (lit_left != 0) lit_left = lit_left - 1'b1;
            if (lit_left == 0) phase = PhOffLo;
         end
         PhOffLo: begin
            off_lo = b;
            phase  = PhOffHi;
         end
         PhOffHi: begin
            off_hi = b;
            if (token[3:0] == NibbleExt) begin
               match_len = MatchExtBase;
               phase     = PhMExt;
            end else begin
               emit  = 1'b1;
               cmd   = make_cmd(1'b1, MatchW'(token[3:0]) + MatchW'(MatchMinLen),
                                is_last, StatusOk);
               phase = PhToken;
            end
         end
         PhMExt: begin
            sum = 32'(match_len) + 32'(b);
            match_len = (sum > 32'(MatchMax)) ? MatchMax : MatchW'(sum);
            if (b != ByteExt) begin
               emit  = 1'b1;
               cmd   = make_cmd(1'b1, match_len, is_last, StatusOk);
               phase = PhToken;
            end
         end
         default: begin
            token     = b;
            lit_start = '0;
            lit_len   = '0;
            if (b[7:4] == NibbleExt) begin
               lit_len = LitLenW'(15);
               phase   = PhLitExt;
            end else begin
               lit_len = LitLenW'(b[7:4]);
               length_known();
            end
         end
      endcase

      // Close the block: without a match command, a clean end only right after the literals
      if (is_last) begin
         if (!emit) begin
            emit = 1'b1;
            cmd  = make_cmd(1'b0, '0, 1'b1,
                            (phase == PhOffLo) ? StatusOk : StatusTruncated);
         end
         clear_state();
      end else begin
         position = next_pos(position);
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("[%0t] command %0d: %s", $realtime, cmd_index, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input longint unsigned got,
                              input longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Predict on each byte transaction, compare on each command transaction
   always @(posedge clock) begin
      bit      emit;
      cmd_type cmd;
      cmd_type want;
      if (reset) begin
         clear_state();
         pending_cmds.delete();
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata, req_tlast, emit, cmd);
            if (emit) pending_cmds.push_back(cmd);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_cmds.size() == 0) begin
               report_mismatch("command arrived with nothing expected");
            end else begin
               want = pending_cmds.pop_front();
               check_field("literal_start", 64'(rsp_tdata[LenLo-1:0]),
                           64'(want.literal_start));
               check_field("literal_length", 64'(rsp_tdata[MatchHm-1:LenLo]),
                           64'(want.literal_length));
               check_field("has_match", 64'(rsp_tdata[MatchHm]), 64'(want.has_match));
               check_field("match_offset", 64'(rsp_tdata[MlenLo-1:OffLo]),
                           64'(want.match_offset));
               check_field("match_length", 64'(rsp_tdata[MlenLo+MatchW-1:MlenLo]),
                           64'(want.match_length));
               check_field("block_done", 64'(rsp_tlast), 64'(want.block_done));
               check_field("status", 64'(rsp_tuser), 64'(want.status));
            end
            cmd_index++;
         end
         pending <= pending_cmds.size();
      end
   end

endmodule

// ===== bench/lz4_block_sequence_parser_top_tb.sv =====
// ----------------------------------------------------------------------------
// lz4_block_sequence_parser_top_tb
// Drives LZ4 compressed blocks into the sequence parser: a short directed
// set, then random well-formed, cut-short and noise blocks with random
// stalls on both channels. The checker predicts and compares the commands;
// this module gives the verdict.
// ----------------------------------------------------------------------------
module lz4_block_sequence_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lz4bsp_pkg::*;

   localparam int BlockBytes    = 4194304;
   localparam int RandomItems   = 1150;
   localparam int WatchdogLimit = 2000;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic                rsp_tuser;

   int         mismatch_count;
   int         pending_count;
   int         idle_cycles = 0;
   int         bytes_sent  = 0;
   bit         quiet       = 1'b0;
   logic [7:0] block_bytes[$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lz4_block_sequence_parser_top #(.MAX_BLOCK_BYTES(BlockBytes)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   lz4bsp_sequence_checker #(.MAX_BLOCK_BYTES(BlockBytes)) seq_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Stall the command channel at random, except in the quiet stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= quiet || ($urandom_range(99) >= 8);
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Offer one byte, with random gaps ahead of it, and hold until accepted
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      while (!quiet && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_block();
      foreach (block_bytes[i]) send_byte(block_bytes[i], i == block_bytes.size() - 1);
   endtask

   // Hold off the byte channel until every predicted command has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Append an extension run worth extra on top of a nibble of 15
   task automatic add_extension(input int extra);
      while (extra >= 255) begin
         block_bytes.push_back(8'hFF);
         extra -= 255;
      end
      block_bytes.push_back(8'(extra));
   endtask

   // Append one sequence; match_extra is the match length less 4
   task automatic add_sequence(input int lits, input int match_extra, input bit with_match,
                               input logic [15:0] offset);
      logic [3:0] lit_nib;
      logic [3:0] match_nib;
      lit_nib   = (lits >= 15) ? 4'hF : 4'(lits);
      match_nib = with_match ? ((match_extra >= 15) ? 4'hF : 4'(match_extra))
                             : 4'($urandom_range(15));
      block_bytes.push_back({lit_nib, match_nib});
      if (lits >= 15) add_extension(lits - 15);
      repeat (lits) block_bytes.push_back(8'($urandom_range(255)));
      if (with_match) begin
         block_bytes.push_back(offset[7:0]);
         block_bytes.push_back(offset[15:8]);
         if (match_extra >= 15) add_extension(match_extra - 15);
      end
   endtask

   function automatic int pick_literals();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(14);
      if (r < 85) return $urandom_range(15, 40);
      if (r < 96) return 15;
      return $urandom_range(270, 560);
   endfunction

   function automatic int pick_match();
      int r;
      r = $urandom_range(99);
      if (r < 50) return $urandom_range(14);
      if (r < 60) return 15;
      if (r < 85) return $urandom_range(16, 300);
      return $urandom_range(300, 1200);
   endfunction

   // Build and send one random block: mostly well formed, some cut, some noise
   task automatic random_block();
      int kind;
      int cut;
      kind = $urandom_range(99);
      block_bytes.delete();
      if (kind < 12) begin
         repeat ($urandom_range(1, 12)) block_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(0, 3))
            add_sequence(pick_literals(), pick_match(), 1'b1, 16'($urandom_range(65535)));
         add_sequence(pick_literals(), 0, 1'b0, '0);
         if (kind < 26 && block_bytes.size() > 1) begin
            cut = $urandom_range(1, block_bytes.size() - 1);
            while (block_bytes.size() > cut) void'(block_bytes.pop_back());
         end
      end
      send_block();
   endtask

   initial begin
      bit drained;
      drained = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Match then a final literal-only sequence
      block_bytes = '{8'h12, 8'hA5, 8'h34, 8'h12, 8'h30, 8'h00, 8'hFF, 8'h7E};
      send_block();
      // Extended match that completes on the final byte, largest offset
      block_bytes = '{8'h0F, 8'hFF, 8'hFF, 8'hFF, 8'h05};
      send_block();
      // Cut inside the offset
      block_bytes = '{8'h00, 8'h00};
      send_block();
      // Cut inside the literal extension
      block_bytes = '{8'hF0};
      send_block();
      // Token alone with no literals
      block_bytes = '{8'h0A};
      send_block();
      // Cut inside the literals
      block_bytes = '{8'h30, 8'h55};
      send_block();
      // Cut inside the match extension
      block_bytes = '{8'h0F, 8'h01, 8'h00, 8'hFF};
      send_block();
      drain();

      // Random blocks, with a stretch free of stalls and one full drain
      bytes_sent = 0;
      while (bytes_sent < RandomItems) begin
         quiet = (bytes_sent >= 400 && bytes_sent < 700);
         if (!drained && bytes_sent >= 600) begin
            drain();
            drained = 1'b1;
         end
         random_block();
      end
      quiet = 1'b0;

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
